@@ src/telemetry_frame_parser_crc8_core_defines.svh @@
// Assertion macros shared by the telemetry frame parser RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef TELEMETRY_FRAME_PARSER_CRC8_CORE_DEFINES_SVH
`define TELEMETRY_FRAME_PARSER_CRC8_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define TFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`else

`define TFP_ASSERT(label, prop, msg)
`define TFP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ src/tfp_pkg.sv @@
// Shared types and the CRC-8 step for the telemetry frame parser.
// No dependencies.
package tfp_pkg;

	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam int unsigned MAX_PAYLOAD = 255;

	typedef struct packed {
		logic [7:0] sync_value;
		logic [7:0] type_mask;
		logic [7:0] type_version;
		logic [5:0] hdr_bytes;
	} cfg_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic        frame_done;
		logic        frame_good;
		logic [8:0]  frame_length;
		logic [7:0]  message_type;
		logic [31:0] object_id;
		logic [15:0] instance_id;
	} result_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] x;
		x = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (x[7]) begin
				x = {x[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				x = {x[6:0], 1'b0};
			end
		end
		return x;
	endfunction

endpackage

@@ src/tfp_parser.sv @@
// Frame parse state machine: sync hunt, header fields, payload and CRC check.
// Depends on tfp_pkg for cfg_t, result_t and crc8_step.
module tfp_parser
	import tfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output result_t    res
);

	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_SYNC = 3'd1,
		PH_LEN  = 3'd2,
		PH_OBJ  = 3'd3,
		PH_INST = 3'd4,
		PH_DATA = 3'd5,
		PH_CRC  = 3'd6
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  crc_q, crc_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [15:0] length_q, length_d;
	logic [7:0]  type_q, type_d;
	logic [31:0] object_q, object_d;
	logic [15:0] instance_q, instance_d;

	logic [7:0]         crc_upd;
	logic signed [17:0] need;
	logic [8:0]         next_cnt;
	logic [15:0]        len_full;
	logic               len_bad;
	logic               data_end;

	assign crc_upd  = crc8_step(crc_q, rx_byte);
	assign need     = signed'({2'b00, length_q}) - signed'({12'd0, cfg.hdr_bytes});
	assign next_cnt = {1'b0, cnt_q} + 9'd1;
	assign len_full = length_q | {rx_byte, 8'h00};
	assign len_bad  = (len_full < {10'd0, cfg.hdr_bytes}) ||
		({1'b0, len_full} > (17'd255 + {11'd0, cfg.hdr_bytes}));
	assign data_end = (signed'({9'd0, next_cnt}) >= need) ||
		(next_cnt >= 9'(MAX_PAYLOAD));

	always_comb begin
		phase_d    = phase_q;
		crc_d      = crc_q;
		cnt_d      = cnt_q;
		length_d   = length_q;
		type_d     = type_q;
		object_d   = object_q;
		instance_d = instance_q;
		res        = '0;
		unique case (phase_q)
			PH_SYNC: begin
				crc_d = crc_upd;
				if ((rx_byte & cfg.type_mask) == cfg.type_version) begin
					type_d  = rx_byte;
					phase_d = PH_LEN;
					cnt_d   = '0;
				end else begin
					phase_d = PH_WAIT;
				end
			end
			PH_LEN: begin
				crc_d = crc_upd;
				if (cnt_q == 8'd0) begin
					length_d = {8'h00, rx_byte};
					cnt_d    = 8'd1;
				end else begin
					length_d = len_full;
					if (len_bad) begin
						phase_d = PH_WAIT;
					end else begin
						phase_d = PH_OBJ;
						cnt_d   = '0;
					end
				end
			end
			PH_OBJ: begin
				crc_d = crc_upd;
				if (cnt_q == 8'd0) begin
					object_d = {24'd0, rx_byte};
					cnt_d    = 8'd1;
				end else begin
					object_d = object_q | ({24'd0, rx_byte} << {cnt_q[1:0], 3'b000});
					if (cnt_q >= 8'd3) begin
						phase_d = PH_INST;
						cnt_d   = '0;
					end else begin
						cnt_d = next_cnt[7:0];
					end
				end
			end
			PH_INST: begin
				crc_d = crc_upd;
				if (cnt_q == 8'd0) begin
					instance_d = {8'h00, rx_byte};
					cnt_d      = 8'd1;
				end else begin
					instance_d = instance_q | {rx_byte, 8'h00};
					cnt_d      = '0;
					phase_d    = (need <= 18'sd0) ? PH_CRC : PH_DATA;
				end
			end
			PH_DATA: begin
				crc_d             = crc_upd;
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = cnt_q;
				if (data_end) begin
					phase_d = PH_CRC;
					cnt_d   = '0;
				end else begin
					cnt_d = next_cnt[7:0];
				end
			end
			PH_CRC: begin
				res.frame_done = 1'b1;
				res.frame_good = (crc_q == rx_byte);
				phase_d        = PH_WAIT;
			end
			default: begin
				phase_d = PH_WAIT;
				if (rx_byte == cfg.sync_value) begin
					phase_d = PH_SYNC;
					crc_d   = crc8_step(8'h00, rx_byte);
				end
			end
		endcase
		res.frame_length = length_d[8:0];
		res.message_type = type_d;
		res.object_id    = object_d;
		res.instance_id  = instance_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT;
			crc_q      <= '0;
			cnt_q      <= '0;
			length_q   <= '0;
			type_q     <= '0;
			object_q   <= '0;
			instance_q <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			crc_q      <= crc_d;
			cnt_q      <= cnt_d;
			length_q   <= length_d;
			type_q     <= type_d;
			object_q   <= object_d;
			instance_q <= instance_d;
		end
	end

endmodule

@@ src/telemetry_frame_parser_crc8_core.sv @@
// Top level of the telemetry frame parser: handshake, configuration, result register.
// Depends on tfp_pkg, tfp_parser and telemetry_frame_parser_crc8_core_defines.svh.
//
// Usage:
//   Byte channel: rx_byte with byte_valid / byte_stall; a transaction completes
//   on a clock edge with byte_valid high and byte_stall low.
//   Result channel: one result transaction per byte, with result_valid /
//   result_stall. Payload bytes come out with their index; the CRC byte gives
//   frame_done and frame_good. Header fields always show the current values.
//   Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
//   Path: the byte transaction lands in the input register; parse logic then
//   loads the result register and raises result_valid.
//   Throughput: one byte per cycle while result_stall does not hold a result;
//   each byte needs one bitwise CRC-8 step and one parse state update.
//   Reset: arst_n clears the parse state, loads the default configuration and
//   empties both registers; no clearing pass.
//   Stall: while result_stall holds a result, one more byte is held in the
//   input register, then byte_stall rises until the result is taken.
`include "telemetry_frame_parser_crc8_core_defines.svh"

module telemetry_frame_parser_crc8_core
	import tfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic [7:0]  payload_index,
	output logic        frame_done,
	output logic        frame_good,
	output logic [8:0]  frame_length,
	output logic [7:0]  message_type,
	output logic [31:0] object_id,
	output logic [15:0] instance_id
);

	localparam logic [1:0] CFG_SYNC    = 2'd0;
	localparam logic [1:0] CFG_MASK    = 2'd1;
	localparam logic [1:0] CFG_VERSION = 2'd2;
	localparam logic [1:0] CFG_HDRLEN  = 2'd3;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	result_t    res;
	result_t    res_q;
	logic       out_free;
	logic       adv;
	logic       load_s1;

	assign out_free   = !result_valid || !result_stall;
	assign adv        = valid_s1 && out_free;
	assign load_s1    = !valid_s1 || adv;
	assign byte_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value   <= 8'd60;
			cfg_q.type_mask    <= 8'd248;
			cfg_q.type_version <= 8'd32;
			cfg_q.hdr_bytes    <= 6'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SYNC:    cfg_q.sync_value   <= cfg_data;
				CFG_MASK:    cfg_q.type_mask    <= cfg_data;
				CFG_VERSION: cfg_q.type_version <= cfg_data;
				CFG_HDRLEN:  cfg_q.hdr_bytes    <= cfg_data[5:0];
				default:     cfg_q              <= cfg_q;
			endcase
		end
	end

	// Input register: advance into parse when the result register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && byte_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	tfp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign payload_valid = res_q.payload_valid;
	assign payload_byte  = res_q.payload_byte;
	assign payload_index = res_q.payload_index;
	assign frame_done    = res_q.frame_done;
	assign frame_good    = res_q.frame_good;
	assign frame_length  = res_q.frame_length;
	assign message_type  = res_q.message_type;
	assign object_id     = res_q.object_id;
	assign instance_id   = res_q.instance_id;

	`TFP_ASSERT(a_stall_needs_s1, byte_stall |-> valid_s1, "byte stall without a held byte")
	`TFP_ASSERT_NEXT(a_adv_gives_result, adv, result_valid, "advanced byte gave no result")
	`TFP_ASSERT(a_done_not_payload, (result_valid && frame_done) |-> !payload_valid, "done on payload")
	`TFP_ASSERT(a_good_needs_done, (result_valid && frame_good) |-> frame_done, "good without done")

endmodule

@@ tb/tb_telemetry_frame_parser_crc8_core.sv @@
// Self-checking testbench for telemetry_frame_parser_crc8_core: drives byte streams with random
// gaps and stalls, predicts every result transaction and compares it field by field.
// Depends on tfp_pkg and the RTL of the block.
module tb_telemetry_frame_parser_crc8_core;
	import tfp_pkg::*;

	typedef enum logic [2:0] {
		HUNT_SYNC, CHECK_TYPE, GET_LENGTH, GET_OBJECT, GET_INSTANCE, GET_PAYLOAD, CHECK_CRC
	} parse_phase_t;

	typedef enum logic [1:0] {
		REG_SYNC, REG_TYPE_MASK, REG_TYPE_VERSION, REG_HEADER_LEN
	} reg_index_t;

	typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_TYPE, FLAW_LEN, FLAW_CUT} frame_flaw_t;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  rx_byte;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        result_valid;
	logic        result_stall;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_index;
	logic        frame_done;
	logic        frame_good;
	logic [8:0]  frame_length;
	logic [7:0]  message_type;
	logic [31:0] object_id;
	logic [15:0] instance_id;

	// predictor copy of configuration and parse state
	logic [7:0]   cfg_sync;
	logic [7:0]   cfg_mask;
	logic [7:0]   cfg_ver;
	logic [5:0]   cfg_hdr;
	parse_phase_t phase_q;
	logic [7:0]   crc_q;
	logic [7:0]   count_q;
	logic [15:0]  length_q;
	logic [7:0]   type_q;
	logic [31:0]  object_q;
	logic [15:0]  instance_q;

	logic [7:0] pending_bytes[$];
	result_t    expected_results[$];
	int         errors;
	int         gap_left;
	int         hold_left;
	bit         byte_taken;
	bit         quiet;
	bit         hold_request;

	telemetry_frame_parser_crc8_core uut (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .rx_byte(rx_byte),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .result_stall(result_stall),
		.payload_valid(payload_valid), .payload_byte(payload_byte),
		.payload_index(payload_index), .frame_done(frame_done), .frame_good(frame_good),
		.frame_length(frame_length), .message_type(message_type),
		.object_id(object_id), .instance_id(instance_id)
	);

	always begin
		#10 clk = ~clk;
	end

	function automatic logic [7:0] crc8_advance(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		repeat (8) c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
		return c;
	endfunction

	function automatic logic [7:0] crc_of(input logic [7:0] bytes[$]);
		logic [7:0] c;
		c = 8'h00;
		foreach (bytes[i]) c = crc8_advance(c, bytes[i]);
		return c;
	endfunction

	function automatic result_t parse_byte(input logic [7:0] b);
		result_t r;
		int need;
		int nxt;
		r = '0;
		need = int'(length_q) - int'(cfg_hdr);
		case (phase_q)
			CHECK_TYPE: begin
				crc_q = crc8_advance(crc_q, b);
				if ((b & cfg_mask) == cfg_ver) begin
					type_q = b;
					phase_q = GET_LENGTH;
					count_q = '0;
				end else begin
					phase_q = HUNT_SYNC;
				end
			end
			GET_LENGTH: begin
				crc_q = crc8_advance(crc_q, b);
				if (count_q == 0) begin
					length_q = {8'h00, b};
					count_q = 8'd1;
				end else begin
					length_q = length_q | {b, 8'h00};
					if (int'(length_q) < int'(cfg_hdr) || int'(length_q) > 255 + int'(cfg_hdr)) begin
						phase_q = HUNT_SYNC;
					end else begin
						phase_q = GET_OBJECT;
						count_q = '0;
					end
				end
			end
			GET_OBJECT: begin
				crc_q = crc8_advance(crc_q, b);
				if (count_q == 0) begin
					object_q = {24'h0, b};
					count_q = 8'd1;
				end else begin
					object_q = object_q | ({24'h0, b} << (8 * count_q[1:0]));
					if (count_q >= 3) begin
						phase_q = GET_INSTANCE;
						count_q = '0;
					end else begin
						count_q = count_q + 8'd1;
					end
				end
			end
			GET_INSTANCE: begin
				crc_q = crc8_advance(crc_q, b);
				if (count_q == 0) begin
					instance_q = {8'h00, b};
					count_q = 8'd1;
				end else begin
					instance_q = instance_q | {b, 8'h00};
					count_q = '0;
					phase_q = (need <= 0) ? CHECK_CRC : GET_PAYLOAD;
				end
			end
			GET_PAYLOAD: begin
				nxt = int'(count_q) + 1;
				crc_q = crc8_advance(crc_q, b);
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				r.payload_index = count_q;
				if (nxt >= need || nxt >= 255) begin
					phase_q = CHECK_CRC;
					count_q = '0;
				end else begin
					count_q = 8'(nxt);
				end
			end
			CHECK_CRC: begin
				r.frame_done = 1'b1;
				r.frame_good = (crc_q == b);
				phase_q = HUNT_SYNC;
			end
			default: begin
				phase_q = HUNT_SYNC;
				if (b == cfg_sync) begin
					phase_q = CHECK_TYPE;
					crc_q = crc8_advance(8'h00, b);
				end
			end
		endcase
		r.frame_length = length_q[8:0];
		r.message_type = type_q;
		r.object_id = object_q;
		r.instance_id = instance_q;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// byte driver
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_taken = 1'b0;
		end else if (!byte_valid || byte_taken) begin
			byte_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				byte_valid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				rx_byte <= pending_bytes.pop_front();
				byte_valid <= 1'b1;
				gap_left = pick_gap();
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// byte transaction: predict
	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall) begin
			expected_results.push_back(parse_byte(rx_byte));
			byte_taken = 1'b1;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 120;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (quiet || $urandom_range(0, 99) < 70) begin
			result_stall <= 1'b0;
		end else begin
			hold_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(8, 30);
			result_stall <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result transaction with no expectation waiting", $time);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("payload_valid", 32'(want.payload_valid), 32'(payload_valid));
				check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
				check_field("payload_index", 32'(want.payload_index), 32'(payload_index));
				check_field("frame_done", 32'(want.frame_done), 32'(frame_done));
				check_field("frame_good", 32'(want.frame_good), 32'(frame_good));
				check_field("frame_length", 32'(want.frame_length), 32'(frame_length));
				check_field("message_type", 32'(want.message_type), 32'(message_type));
				check_field("object_id", want.object_id, object_id);
				check_field("instance_id", 32'(want.instance_id), 32'(instance_id));
			end
		end
	end

	task automatic write_reg(input reg_index_t idx, input logic [7:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_SYNC: cfg_sync = data;
			REG_TYPE_MASK: cfg_mask = data;
			REG_TYPE_VERSION: cfg_ver = data;
			default: cfg_hdr = data[5:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] s, input logic [7:0] m, input logic [7:0] v,
			input logic [7:0] h);
		write_reg(REG_SYNC, s);
		write_reg(REG_TYPE_MASK, m);
		write_reg(REG_TYPE_VERSION, v);
		write_reg(REG_HEADER_LEN, h);
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() > 0 || byte_valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic add_frame(input int plen, input frame_flaw_t flaw, output int nbytes);
		logic [7:0] fb[$];
		logic [7:0] t;
		logic [7:0] c;
		logic [15:0] len;
		int tries;
		int cut;
		fb.push_back(cfg_sync);
		if (flaw == FLAW_TYPE) begin
			t = 8'($urandom);
			tries = 0;
			while ((t & cfg_mask) == cfg_ver && tries < 64) begin
				t = 8'($urandom);
				tries++;
			end
		end else begin
			t = (cfg_ver & cfg_mask) | (8'($urandom) & ~cfg_mask);
		end
		fb.push_back(t);
		if (flaw != FLAW_TYPE) begin
			len = 16'(cfg_hdr) + 16'(plen);
			if (flaw == FLAW_LEN) begin
				if (cfg_hdr > 0 && $urandom_range(0, 1))
					len = 16'($urandom_range(0, cfg_hdr - 1));
				else
					len = 16'($urandom_range(int'(cfg_hdr) + 256, 65535));
			end
			fb.push_back(len[7:0]);
			fb.push_back(len[15:8]);
		end
		if (flaw != FLAW_TYPE && flaw != FLAW_LEN) begin
			repeat (6 + plen) fb.push_back(8'($urandom));
			c = crc_of(fb);
			if (flaw == FLAW_CRC)
				c = c ^ (8'h01 << $urandom_range(0, 7));
			fb.push_back(c);
			if (flaw == FLAW_CUT) begin
				cut = $urandom_range(1, fb.size() - 1);
				fb = fb[0:cut - 1];
			end
		end
		foreach (fb[i]) pending_bytes.push_back(fb[i]);
		nbytes = fb.size();
	endtask

	task automatic random_traffic(input int target);
		int sent;
		int n;
		int r;
		int plen;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(0, 19) == 0)
				quiet = !quiet;
			r = $urandom_range(0, 99);
			n = $urandom_range(0, 99);
			plen = (n < 80) ? $urandom_range(0, 16) :
				(n < 98) ? $urandom_range(17, 64) : 255;
			if (r < 8) begin
				repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom));
			end else if (r < 78) begin
				add_frame(plen, FLAW_NONE, n);
				sent += n;
			end else if (r < 86) begin
				add_frame(plen, FLAW_CRC, n);
				sent += n;
			end else if (r < 91) begin
				add_frame(plen, FLAW_TYPE, n);
				sent += n;
			end else if (r < 96) begin
				add_frame(plen, FLAW_LEN, n);
				sent += n;
			end else begin
				add_frame(plen, FLAW_CUT, n);
				sent += n;
			end
			while (pending_bytes.size() > 300)
				@(negedge clk);
		end
		quiet = 1'b0;
	endtask

	initial begin
		logic [7:0] fb[$];
		logic [7:0] m;
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		rx_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_index = REG_SYNC;
		cfg_data = 8'h00;
		result_stall = 1'b0;
		errors = 0;
		gap_left = 0;
		hold_left = 0;
		quiet = 1'b0;
		hold_request = 1'b0;
		cfg_sync = 8'd60;
		cfg_mask = 8'd248;
		cfg_ver = 8'd32;
		cfg_hdr = 6'd10;
		phase_q = HUNT_SYNC;
		crc_q = '0;
		count_q = '0;
		length_q = '0;
		type_q = '0;
		object_q = '0;
		instance_q = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty payload, bad crc, type byte equal to sync, bad length
		add_frame(0, FLAW_NONE, n);
		add_frame(1, FLAW_CRC, n);
		pending_bytes.push_back(cfg_sync);
		pending_bytes.push_back(cfg_sync);
		add_frame(0, FLAW_LEN, n);
		wait_idle();

		// header length raised mid-frame: crc byte follows the instance id
		fb = {cfg_sync, 8'h21, 8'd15, 8'h00, 8'hEF, 8'hBE, 8'hAD, 8'hDE, 8'h34};
		foreach (fb[i]) pending_bytes.push_back(fb[i]);
		wait_idle();
		write_reg(REG_HEADER_LEN, 8'd40);
		fb.push_back(8'h12);
		pending_bytes.push_back(8'h12);
		pending_bytes.push_back(crc_of(fb));
		wait_idle();
		write_reg(REG_HEADER_LEN, 8'd10);
		random_traffic(160);
		wait_idle();

		// hold the receiver off while frames keep arriving
		set_config(8'h00, 8'hFF, 8'hA5, 8'h00);
		quiet = 1'b1;
		hold_request = 1'b1;
		add_frame(255, FLAW_NONE, n);
		add_frame(0, FLAW_NONE, n);
		wait_idle();
		quiet = 1'b0;
		random_traffic(160);
		wait_idle();

		set_config(8'hFF, 8'h00, 8'h00, 8'hFF);
		random_traffic(175);
		wait_idle();

		set_config(8'h7E, 8'hF0, 8'h30, 8'h01);
		random_traffic(175);
		wait_idle();

		set_config(8'h3C, 8'hF8, 8'h20, 8'd32);
		random_traffic(175);
		wait_idle();

		m = 8'($urandom);
		set_config(8'($urandom), m, 8'($urandom) & m, 8'($urandom_range(0, 63)));
		random_traffic(175);
		wait_idle();
		repeat (6) @(negedge clk);

		if (errors == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#12000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
